[src/surround_channel_remix_assert.svh]
// Assertion macros used by the RTL of the channel remix block.
`ifndef SURROUND_CHANNEL_REMIX_ASSERT_SVH
`define SURROUND_CHANNEL_REMIX_ASSERT_SVH

// Immediate-style implication checked at every rising edge outside reset.
`define SCR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence checked a fixed number of cycles after the antecedent.
`define SCR_ASSERT_DELAY(label, clk, rst_n, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define SCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/scr_pkg.sv]
package scr_pkg;

    localparam int NUM_SLOTS  = 6;
    localparam int PIPE_DEPTH = 4;

    // Q15 weights for the 5.1 to stereo fold.
    localparam logic signed [14:0] W_FRONT  = 15'sd12104;
    localparam logic signed [14:0] W_CENTRE = 15'sd8559;

    // Configuration register indexes.
    localparam logic [1:0] REG_SINK_ENABLED    = 2'd0;
    localparam logic [1:0] REG_SOURCE_CHANNELS = 2'd1;
    localparam logic [1:0] REG_STREAM_CHANNELS = 2'd2;

    typedef logic [1:0] cfg_index_t;
    typedef logic [2:0] cfg_data_t;

    typedef enum logic [3:0] {
        MODE_SILENT,
        MODE_COPY0,
        MODE_MONO2,
        MODE_MONO6,
        MODE_STEREO2,
        MODE_STEREO6,
        MODE_SURR1,
        MODE_SURR2,
        MODE_SURR6
    } mode_t;

    // Clamp a signed 32-bit value to the signed 16-bit range.
    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v[31:15] == {17{1'b0}} || v[31:15] == {17{1'b1}}) begin
            r = v[15:0];
        end else if (v[31]) begin
            r = 16'sh8000;
        end else begin
            r = 16'sh7fff;
        end
        return r;
    endfunction

    // Pick the routing rule from the sink and channel count settings.
    function automatic mode_t decode_mode(input logic en, input logic [2:0] src,
                                          input logic [2:0] strm);
        mode_t m;
        m = MODE_SILENT;
        if (en && (strm inside {3'd1, 3'd2, 3'd6})) begin
            case (src)
                3'd1: begin
                    case (strm)
                        3'd1:    m = MODE_COPY0;
                        3'd2:    m = MODE_MONO2;
                        default: m = MODE_MONO6;
                    endcase
                end
                3'd2: begin
                    case (strm)
                        3'd1:    m = MODE_COPY0;
                        3'd2:    m = MODE_STEREO2;
                        default: m = MODE_STEREO6;
                    endcase
                end
                3'd6: begin
                    case (strm)
                        3'd1:    m = MODE_SURR1;
                        3'd2:    m = MODE_SURR2;
                        default: m = MODE_SURR6;
                    endcase
                end
                default: m = MODE_SILENT;
            endcase
        end
        return m;
    endfunction

endpackage

[src/surround_channel_remix.sv]
// Channel remix for one audio frame per transaction. A frame of six signed
// 32-bit mix samples (FL or mono, FR, FC, LFE, BL, BR) is taken when start is
// high and busy is low; busy is never raised, so a new frame may be offered in
// every cycle. The six signed 16-bit stream slots leave the output register and
// appear for a single cycle with done high. The receiver cannot stall, so the
// results must be captured in the cycle that done is high. Each used source
// sample is saturated to 16 bits, then routed by the pair of source and stream
// channel counts (1, 2 or 6): mono is copied to every slot but the LFE, stereo to
// 5.1 adds a centre of (L+R)/2 truncated toward zero with a silent LFE, and 5.1
// to stereo folds with Q15 weights 0.3694 and 0.2612, truncated toward zero and
// saturated. Unsupported counts or a disabled sink give an all-zero frame, and
// slots beyond the stream count are zero. The pipeline stages are input
// saturation and rule decode, the weight multipliers, the three-term
// accumulation, and the rounding, clamp and slot select that feeds the output
// register. Throughput is one frame per clock.
// Configuration registers are written through the cfg_valid/cfg_ready channel,
// which is always ready; writes should only happen while no frame is in
// flight, because the rule is sampled as a frame enters the pipeline.
`include "surround_channel_remix_assert.svh"

module surround_channel_remix (
    input  logic                clk,
    input  logic                rst_n,
    // Frame input, command style.
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  mix_ch0,
    input  logic signed [31:0]  mix_ch1,
    input  logic signed [31:0]  mix_ch2,
    input  logic signed [31:0]  mix_ch3,
    input  logic signed [31:0]  mix_ch4,
    input  logic signed [31:0]  mix_ch5,
    // Result frame, valid for one cycle while done is high.
    output logic                done,
    output logic signed [15:0]  out_slot0,
    output logic signed [15:0]  out_slot1,
    output logic signed [15:0]  out_slot2,
    output logic signed [15:0]  out_slot3,
    output logic signed [15:0]  out_slot4,
    output logic signed [15:0]  out_slot5,
    // Configuration write channel.
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  scr_pkg::cfg_index_t cfg_index,
    input  scr_pkg::cfg_data_t  cfg_data
);
    import scr_pkg::*;

    // Configuration registers.
    logic       sink_enabled_reg;
    logic [2:0] source_channels_reg;
    logic [2:0] stream_channels_reg;

    // Stage 1: saturated samples and the decoded routing rule.
    logic                v1_reg;
    mode_t               mode1_reg;
    logic signed [15:0]  s1_reg [NUM_SLOTS];
    logic signed [15:0]  s1_next [NUM_SLOTS];

    // Stage 2: weighted products and the stereo centre.
    logic                v2_reg;
    mode_t               mode2_reg;
    logic signed [15:0]  s2_reg [NUM_SLOTS];
    logic signed [30:0]  pl2_reg [3];
    logic signed [30:0]  pr2_reg [3];
    logic signed [15:0]  centre2_reg;
    logic signed [15:0]  centre2_next;
    logic signed [16:0]  pair_sum;
    logic signed [16:0]  pair_half;

    // Stage 3: fold accumulators.
    logic                v3_reg;
    mode_t               mode3_reg;
    logic signed [15:0]  s3_reg [NUM_SLOTS];
    logic signed [15:0]  centre3_reg;
    logic signed [31:0]  accl3_reg;
    logic signed [31:0]  accr3_reg;

    // Stage 4: output register.
    logic                done_reg;
    logic signed [15:0]  out_reg [NUM_SLOTS];
    logic signed [15:0]  out_next [NUM_SLOTS];
    logic signed [31:0]  foldl_q;
    logic signed [31:0]  foldr_q;
    logic signed [15:0]  foldl_sat;
    logic signed [15:0]  foldr_sat;

    logic [31:0] mix_in [NUM_SLOTS];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    assign mix_in[0] = mix_ch0;
    assign mix_in[1] = mix_ch1;
    assign mix_in[2] = mix_ch2;
    assign mix_in[3] = mix_ch3;
    assign mix_in[4] = mix_ch4;
    assign mix_in[5] = mix_ch5;

    // Configuration writes; an index past the register list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_enabled_reg    <= 1'b0;
            source_channels_reg <= 3'd2;
            stream_channels_reg <= 3'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SINK_ENABLED:    sink_enabled_reg    <= cfg_data[0];
                REG_SOURCE_CHANNELS: source_channels_reg <= cfg_data;
                REG_STREAM_CHANNELS: stream_channels_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Valid bits travel with the frame; the pipeline never stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    // Stage 1 logic: clamp each source sample.
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            s1_next[i] = sat16(mix_in[i]);
        end
    end

    // Stage 2 logic: the centre of a stereo pair, truncated toward zero.
    // The half always fits in 16 bits, so no clamp is needed.
    always_comb
    begin
        pair_sum     = 17'(s1_reg[0]) + 17'(s1_reg[1]);
        pair_half    = (pair_sum + (pair_sum[16] ? 17'sd1 : 17'sd0)) >>> 1;
        centre2_next = pair_half[15:0];
    end

    // Stage 4 logic: divide by 32768 toward zero, clamp, route to slots.
    // The accumulators stay inside 31 bits, so the bias cannot overflow.
    always_comb
    begin
        foldl_q   = (accl3_reg + (accl3_reg[31] ? 32'sd32767 : 32'sd0)) >>> 15;
        foldr_q   = (accr3_reg + (accr3_reg[31] ? 32'sd32767 : 32'sd0)) >>> 15;
        foldl_sat = sat16(foldl_q);
        foldr_sat = sat16(foldr_q);
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            out_next[i] = '0;
        end
        case (mode3_reg)
            MODE_COPY0:
            begin
                out_next[0] = s3_reg[0];
            end
            MODE_MONO2:
            begin
                out_next[0] = s3_reg[0];
                out_next[1] = s3_reg[0];
            end
            MODE_MONO6:
            begin
                out_next[0] = s3_reg[0];
                out_next[1] = s3_reg[0];
                out_next[2] = s3_reg[0];
                out_next[4] = s3_reg[0];
                out_next[5] = s3_reg[0];
            end
            MODE_STEREO2:
            begin
                out_next[0] = s3_reg[0];
                out_next[1] = s3_reg[1];
            end
            MODE_STEREO6:
            begin
                out_next[0] = s3_reg[0];
                out_next[1] = s3_reg[1];
                out_next[2] = centre3_reg;
                out_next[4] = s3_reg[0];
                out_next[5] = s3_reg[1];
            end
            MODE_SURR1:
            begin
                out_next[0] = s3_reg[2];
            end
            MODE_SURR2:
            begin
                out_next[0] = foldl_sat;
                out_next[1] = foldr_sat;
            end
            MODE_SURR6:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    out_next[i] = s3_reg[i];
                end
            end
            default:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    out_next[i] = '0;
                end
            end
        endcase
    end

    // Payload pipeline registers; they carry no reset.
    always_ff @(posedge clk)
    begin
        mode1_reg <= decode_mode(sink_enabled_reg, source_channels_reg, stream_channels_reg);
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            s1_reg[i] <= s1_next[i];
        end

        mode2_reg   <= mode1_reg;
        centre2_reg <= centre2_next;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            s2_reg[i] <= s1_reg[i];
        end
        pl2_reg[0] <= 31'(s1_reg[0]) * 31'(W_FRONT);
        pl2_reg[1] <= 31'(s1_reg[2]) * 31'(W_CENTRE);
        pl2_reg[2] <= 31'(s1_reg[4]) * 31'(W_FRONT);
        pr2_reg[0] <= 31'(s1_reg[1]) * 31'(W_FRONT);
        pr2_reg[1] <= 31'(s1_reg[2]) * 31'(W_CENTRE);
        pr2_reg[2] <= 31'(s1_reg[5]) * 31'(W_FRONT);

        mode3_reg   <= mode2_reg;
        centre3_reg <= centre2_reg;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            s3_reg[i] <= s2_reg[i];
        end
        accl3_reg <= 32'(pl2_reg[0]) + 32'(pl2_reg[1]) + 32'(pl2_reg[2]);
        accr3_reg <= 32'(pr2_reg[0]) + 32'(pr2_reg[1]) + 32'(pr2_reg[2]);

        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            out_reg[i] <= out_next[i];
        end
    end

    assign done      = done_reg;
    assign out_slot0 = out_reg[0];
    assign out_slot1 = out_reg[1];
    assign out_slot2 = out_reg[2];
    assign out_slot3 = out_reg[3];
    assign out_slot4 = out_reg[4];
    assign out_slot5 = out_reg[5];

    // Every accepted frame comes out after the full pipeline depth.
    `SCR_ASSERT_DELAY(a_frame_latency, clk, rst_n, start && !busy, 4, done, "accepted frame did not complete after four cycles")

    // A silent rule must reach the output as an all-zero frame.
    `SCR_ASSERT_NEXT(a_silent_zero, clk, rst_n, v3_reg && mode3_reg == MODE_SILENT, done && out_slot0 == '0 && out_slot1 == '0 && out_slot2 == '0 && out_slot3 == '0 && out_slot4 == '0 && out_slot5 == '0, "silent rule produced a nonzero slot")

    // Only the full 5.1 pass-through ever drives the LFE slot.
    `SCR_ASSERT_IMPLY(a_lfe_only_surr6, clk, rst_n, done && out_slot3 != '0, $past(mode3_reg) == MODE_SURR6, "LFE slot driven by a rule other than 5.1 pass-through")

endmodule
